### sv/mi3_pkg.sv
`timescale 1ns / 1ps
package mi3_pkg;

  // raw significand width: 24x24 product plus headroom
  localparam int RW = 50;
  localparam int NEL = 9;
  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG = 31'h7F80_0000;
  localparam logic [30:0] THR_RESET = 31'h2EDB_E6FF;
  localparam logic signed [10:0] BIAS = 11'sd127;

  // operand indexes of the eighteen cofactor products, two per cofactor
  localparam logic [3:0] PA [18] = '{4'd4, 4'd5, 4'd2, 4'd1, 4'd1, 4'd2, 4'd5, 4'd3, 4'd0,
                                     4'd2, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd0, 4'd0, 4'd1};
  localparam logic [3:0] PB [18] = '{4'd8, 4'd7, 4'd7, 4'd8, 4'd5, 4'd4, 4'd6, 4'd8, 4'd8,
                                     4'd6, 4'd3, 4'd5, 4'd7, 4'd6, 4'd6, 4'd7, 4'd4, 4'd3};

  // unrounded value: man * 2^(ex - 127 - 46), specials as flags
  typedef struct packed {
    logic                 nan;
    logic                 inf;
    logic                 sgn;
    logic signed [10:0]   ex;
    logic [RW-1:0]        man;
  } fraw_t;

  // adder operands after compare and swap
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        sgn;
    logic        eff_sub;
    logic [7:0]  ex;
    logic [7:0]  dif;
    logic [23:0] mbig;
    logic [23:0] msml;
  } fcmp_t;

  // single multiply: unpack and full 24x24 product
  function automatic fraw_t fmul_front(input logic [31:0] a, input logic [31:0] b);
    fraw_t r;
    logic a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [7:0] ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] prod;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    b_zero = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    prod = ma * mb;
    r.nan = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    r.inf = a_inf | b_inf;
    r.sgn = a[31] ^ b[31];
    r.ex  = $signed({3'b000, ea}) + $signed({3'b000, eb}) - BIAS;
    r.man = {2'b00, prod};
    return r;
  endfunction

  // add front half: classify, order by magnitude, exponent difference
  function automatic fcmp_t fadd_cmp(input logic [31:0] a, input logic [31:0] b,
                                     input logic sub);
    fcmp_t r;
    logic bs, swap, a_nan, a_inf, b_nan, b_inf;
    logic [31:0] big, sml;
    logic [7:0] ebig, esml;
    bs    = b[31] ^ sub;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    swap  = b[30:0] > a[30:0];
    big   = swap ? {bs, b[30:0]} : a;
    sml   = swap ? a : {bs, b[30:0]};
    ebig  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    esml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    r.eff_sub = a[31] ^ bs;
    r.nan  = a_nan | b_nan | (a_inf & b_inf & r.eff_sub);
    r.inf  = a_inf | b_inf;
    // exact cancellation gives +0
    r.sgn  = (r.eff_sub && (a[30:0] == b[30:0])) ? 1'b0 : big[31];
    r.ex   = ebig;
    r.dif  = ebig - esml;
    r.mbig = {big[30:23] != 8'd0, big[22:0]};
    r.msml = {sml[30:23] != 8'd0, sml[22:0]};
    return r;
  endfunction

  // add back half: align the smaller operand with sticky, then add or subtract
  function automatic fraw_t fadd_sum(input fcmp_t c);
    fraw_t r;
    logic [RW-1:0] bg, sm, al;
    logic [2*RW-1:0] wide;
    logic [5:0] sh;
    logic stk;
    bg   = {3'b000, c.mbig, 23'd0};
    sm   = {3'b000, c.msml, 23'd0};
    sh   = (c.dif > 8'd50) ? 6'd50 : c.dif[5:0];
    wide = {sm, {RW{1'b0}}} >> sh;
    al   = wide[2*RW-1:RW];
    stk  = |wide[RW-1:0];
    al[0] = al[0] | stk;
    r.nan = c.nan;
    r.inf = c.inf;
    r.sgn = c.sgn;
    r.ex  = $signed({3'b000, c.ex});
    r.man = c.eff_sub ? (bg - al) : (bg + al);
    return r;
  endfunction

endpackage

### sv/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// throughput: one matrix per cycle while out_tready is high; depth is set by the
// 14-stage reciprocal divider (two quotient bits per stage) and the 3-stage float
// multiply and 4-stage float add units
// stalls collapse bubbles stage by stage; in_tready drops only when every stage is full
// reset clears all valid bits and sets the threshold to 1e-10
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // inv_00, inv_01, inv_02, inv_10, ... inv_22
  output logic         out_tuser,  // invertible
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data
);

  localparam int NS = 41;

  logic [NS-1:0] v_r, en;
  logic [30:0] thr_r;

  logic [31:0] m_r [8][9];
  fraw_t pr_r [18];
  logic [31:0] pf [18];
  fcmp_t ac_r [10];
  fraw_t sr_r [10];
  logic [31:0] cf [10];
  logic [31:0] cof_r [8:36][9];
  fraw_t dp_r [3];
  logic [31:0] pd [3];
  logic [31:0] p2_r [11:14];
  fcmp_t tc_r, dc_r;
  fraw_t ts_r, ds_r;
  logic [31:0] tf, det, rf;
  logic sing;
  logic sg_r [19:39];
  fraw_t rr;
  fraw_t fr_r [9];
  logic [31:0] inv [9];
  logic [31:0] out_inv_r [9];
  logic out_ok_r;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // per-stage advance: a stage moves when empty or when the next one moves
  assign en[NS-1] = ~v_r[NS-1] | out_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = ~v_r[k] | en[k+1];
  end
  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // input elements and their carry line
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < NEL; j++) m_r[0][j] <= in_tdata[32*j +: 32];
    end
    for (int k = 1; k < 8; k++) begin
      if (en[k]) m_r[k] <= m_r[k-1];
    end
  end

  // cofactor products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 18; i++) pr_r[i] <= fmul_front(m_r[0][PA[i]], m_r[0][PB[i]]);
    end
  end

  for (genvar i = 0; i < 18; i++) begin : g_pn
    mi3_fnorm u_pn (.clk(clk), .adv(en[3:2]), .raw_i(pr_r[i]), .res_o(pf[i]));
  end

  // nine cofactor differences plus the determinant's second minor
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int j = 0; j < NEL; j++) ac_r[j] <= fadd_cmp(pf[2*j], pf[2*j+1], 1'b1);
      ac_r[9] <= fadd_cmp(pf[7], pf[6], 1'b1);
    end
    if (en[5]) begin
      for (int j = 0; j < 10; j++) sr_r[j] <= fadd_sum(ac_r[j]);
    end
  end

  for (genvar j = 0; j < 10; j++) begin : g_cn
    mi3_fnorm u_cn (.clk(clk), .adv(en[7:6]), .raw_i(sr_r[j]), .res_o(cf[j]));
  end

  // adjugate carried to the final multiply
  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int j = 0; j < NEL; j++) cof_r[8][j] <= cf[j];
    end
    for (int k = 9; k < 37; k++) begin
      if (en[k]) cof_r[k] <= cof_r[k-1];
    end
  end

  // first-row expansion products
  always_ff @(posedge clk) begin
    if (en[8]) begin
      dp_r[0] <= fmul_front(m_r[7][0], cf[0]);
      dp_r[1] <= fmul_front(m_r[7][1], cf[9]);
      dp_r[2] <= fmul_front(m_r[7][2], cf[6]);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_dn
    mi3_fnorm u_dn (.clk(clk), .adv(en[10:9]), .raw_i(dp_r[i]), .res_o(pd[i]));
  end

  // t = p0 - p1, third product waits alongside
  always_ff @(posedge clk) begin
    if (en[11]) begin
      tc_r     <= fadd_cmp(pd[0], pd[1], 1'b1);
      p2_r[11] <= pd[2];
    end
    if (en[12]) begin
      ts_r     <= fadd_sum(tc_r);
      p2_r[12] <= p2_r[11];
    end
    if (en[13]) p2_r[13] <= p2_r[12];
    if (en[14]) p2_r[14] <= p2_r[13];
  end

  mi3_fnorm u_tn (.clk(clk), .adv(en[14:13]), .raw_i(ts_r), .res_o(tf));

  // det = t + p2
  always_ff @(posedge clk) begin
    if (en[15]) dc_r <= fadd_cmp(tf, p2_r[14], 1'b0);
    if (en[16]) ds_r <= fadd_sum(dc_r);
  end

  mi3_fnorm u_detn (.clk(clk), .adv(en[18:17]), .raw_i(ds_r), .res_o(det));

  // singular test, false for a nan on either side
  assign sing = (det[30:0] <= INF_MAG) && (thr_r <= INF_MAG) && (det[30:0] < thr_r);

  always_ff @(posedge clk) begin
    if (en[19]) sg_r[19] <= sing;
    for (int k = 20; k < 40; k++) begin
      if (en[k]) sg_r[k] <= sg_r[k-1];
    end
  end

  // reciprocal of the determinant
  mi3_recip u_rcp (.clk(clk), .adv(en[34:19]), .det_i(det), .raw_o(rr));

  mi3_fnorm u_rn (.clk(clk), .adv(en[36:35]), .raw_i(rr), .res_o(rf));

  // scale the adjugate
  always_ff @(posedge clk) begin
    if (en[37]) begin
      for (int j = 0; j < NEL; j++) fr_r[j] <= fmul_front(cof_r[36][j], rf);
    end
  end

  for (genvar j = 0; j < NEL; j++) begin : g_on
    mi3_fnorm u_on (.clk(clk), .adv(en[39:38]), .raw_i(fr_r[j]), .res_o(inv[j]));
  end

  // output register, zeros for a singular matrix
  always_ff @(posedge clk) begin
    if (en[40]) begin
      for (int j = 0; j < NEL; j++) out_inv_r[j] <= sg_r[39] ? 32'd0 : inv[j];
      out_ok_r <= ~sg_r[39];
    end
  end

  for (genvar j = 0; j < NEL; j++) begin : g_out
    assign out_tdata[32*j +: 32] = out_inv_r[j];
  end
  assign out_tuser = out_ok_r;

  // a singular result carries all-zero data
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("singular result with nonzero data");

  // input is refused only when the whole pipeline is full and stalled
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r) && !out_tready)
    else $error("input refused with room in the pipeline");

  // a stalled item in the first stage stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !en[0] |=> v_r[0] && $stable(m_r[0][0]))
    else $error("stalled input stage lost its item");

endmodule

### sv/mi3_fnorm.sv
`timescale 1ns / 1ps
module mi3_fnorm import mi3_pkg::*; (
  input  logic        clk,
  input  logic [1:0]  adv,
  input  fraw_t       raw_i,
  output logic [31:0] res_o
);

  typedef struct packed {
    logic          nan;
    logic          inf;
    logic          sgn;
    logic          zero;
    logic          ovf;
    logic          lft;
    logic [5:0]    sh;
    logic [7:0]    exf;
    logic [RW-1:0] man;
  } fnrm_t;

  fnrm_t n_nxt, n_r;
  logic [5:0] lz;
  logic signed [10:0] lim, lz_s, ef, neg;
  logic [2*RW-1:0] wide;
  logic [RW-1:0] sv;
  logic [23:0] m24;
  logic gd, st, stk, inc;
  logic [30:0] pk;
  logic [31:0] res_nxt;

  // leading zero count and shift plan (normal or subnormal result)
  always_comb begin
    lz = 6'd50;
    for (int i = 0; i < RW; i++) begin
      if (raw_i.man[i]) lz = 6'(RW - 1 - i);
    end
    lim  = raw_i.ex + 11'sd2;
    lz_s = $signed({5'b00000, lz});
    neg  = -lim;
    n_nxt.nan  = raw_i.nan;
    n_nxt.inf  = raw_i.inf;
    n_nxt.sgn  = raw_i.sgn;
    n_nxt.zero = (raw_i.man == '0);
    n_nxt.man  = raw_i.man;
    if (lim >= lz_s) begin
      n_nxt.lft = 1'b1;
      n_nxt.sh  = lz;
      ef        = raw_i.ex + 11'sd3 - lz_s;
    end else if (lim >= 11'sd0) begin
      n_nxt.lft = 1'b1;
      n_nxt.sh  = lim[5:0];
      ef        = 11'sd0;
    end else begin
      n_nxt.lft = 1'b0;
      n_nxt.sh  = (neg > 11'sd50) ? 6'd50 : neg[5:0];
      ef        = 11'sd0;
    end
    n_nxt.ovf = (ef > 11'sd254);
    n_nxt.exf = ef[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) n_r <= n_nxt;
  end

  // shift, round to nearest even, pack
  always_comb begin
    wide = {n_r.man, {RW{1'b0}}} >> n_r.sh;
    sv   = n_r.lft ? (n_r.man << n_r.sh) : wide[2*RW-1:RW];
    stk  = n_r.lft ? 1'b0 : (|wide[RW-1:0]);
    m24  = sv[RW-1:RW-24];
    gd   = sv[RW-25];
    st   = (|sv[RW-26:0]) | stk;
    inc  = gd & (st | m24[0]);
    pk   = {n_r.exf, m24[22:0]} + {30'd0, inc};
    if (n_r.nan) begin
      res_nxt = QNAN;
    end else if (n_r.inf || n_r.ovf) begin
      res_nxt = {n_r.sgn, INF_MAG};
    end else if (n_r.zero) begin
      res_nxt = {n_r.sgn, 31'd0};
    end else begin
      res_nxt = {n_r.sgn, pk};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) res_o <= res_nxt;
  end

endmodule

### sv/mi3_recip.sv
`timescale 1ns / 1ps
module mi3_recip import mi3_pkg::*; (
  input  logic        clk,
  input  logic [15:0] adv,
  input  logic [31:0] det_i,
  output fraw_t       raw_o
);

  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sgn;
    logic [7:0]  e;
    logic [23:0] m24;
    logic [4:0]  lz;
  } rcu_t;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sgn;
    logic signed [10:0] ed;
    logic [23:0]        mn;
    logic [24:0]        rem;
    logic [27:0]        q;
  } dv_t;

  // one restoring step: one quotient bit
  function automatic dv_t div_step(input dv_t s);
    dv_t r;
    r = s;
    if (s.rem >= {1'b0, s.mn}) begin
      r.q   = {s.q[26:0], 1'b1};
      r.rem = (s.rem - {1'b0, s.mn}) << 1;
    end else begin
      r.q   = {s.q[26:0], 1'b0};
      r.rem = s.rem << 1;
    end
    return r;
  endfunction

  rcu_t u_nxt, u_r;
  dv_t d0_nxt;
  dv_t dv_r [15];
  logic stk;

  // classify and count leading zeros of the significand
  always_comb begin
    u_nxt.nan  = (det_i[30:23] == 8'hFF) && (det_i[22:0] != 23'd0);
    u_nxt.inf  = (det_i[30:23] == 8'hFF) && (det_i[22:0] == 23'd0);
    u_nxt.zero = (det_i[30:0] == 31'd0);
    u_nxt.sgn  = det_i[31];
    u_nxt.e    = (det_i[30:23] == 8'd0) ? 8'd1 : det_i[30:23];
    u_nxt.m24  = {det_i[30:23] != 8'd0, det_i[22:0]};
    u_nxt.lz   = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (u_nxt.m24[i]) u_nxt.lz = 5'(23 - i);
    end
  end

  // normalize divisor, start with a dividend of one
  always_comb begin
    d0_nxt.nan  = u_r.nan;
    d0_nxt.inf  = u_r.inf;
    d0_nxt.zero = u_r.zero;
    d0_nxt.sgn  = u_r.sgn;
    d0_nxt.ed   = $signed({3'b000, u_r.e}) - $signed({6'd0, u_r.lz});
    d0_nxt.mn   = u_r.m24 << u_r.lz;
    d0_nxt.rem  = 25'h080_0000;
    d0_nxt.q    = 28'd0;
  end

  // two quotient bits per stage
  always_ff @(posedge clk) begin
    if (adv[0]) u_r <= u_nxt;
    if (adv[1]) dv_r[0] <= d0_nxt;
    for (int k = 1; k < 15; k++) begin
      if (adv[k+1]) dv_r[k] <= div_step(div_step(dv_r[k-1]));
    end
  end

  // quotient as unrounded value, remainder folds into sticky
  assign stk = (dv_r[14].rem != 25'd0);

  always_comb begin
    raw_o.nan = dv_r[14].nan;
    raw_o.inf = dv_r[14].zero;
    raw_o.sgn = dv_r[14].sgn;
    raw_o.ex  = 11'sd254 - dv_r[14].ed;
    raw_o.man = dv_r[14].inf ? '0 : ({3'b000, dv_r[14].q, 19'd0} | {{(RW-1){1'b0}}, stk});
  end

endmodule
